FILE: sv/mlfq_pkg.sv
// shared types and constants of the feedback queue scheduler
`default_nettype none

package mlfq_pkg;

	localparam int LEVELS    = 3;
	localparam int LVL_W     = 2;
	localparam int ID_W      = 4;
	localparam int BURST_W   = 16;
	localparam int STAMP_W   = 16;
	localparam int QUANT_W   = 10;
	localparam int CFG_IDX_W = 2;
	localparam int STATUS_W  = 3;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 72;
	localparam int M_PAD_W   = M_TDATA_W - (ID_W + LVL_W + 4 * STAMP_W);

	typedef logic [LVL_W-1:0]   lvl_t;
	typedef logic [QUANT_W-1:0] quant_t;

	localparam lvl_t LVL_TOP = 2'd0;
	localparam lvl_t LVL_MID = 2'd1;
	localparam lvl_t LVL_BOT = 2'd2;

	localparam quant_t QUANT_RESET [LEVELS] = '{10'd4, 10'd8, 10'd16};

	localparam logic [CFG_IDX_W-1:0] CFG_QUANT_TOP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANT_MID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANT_BOT = 2'd2;

	localparam logic REQ_ARRIVE = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED  = 3'd0,
		ST_REJECTED  = 3'd1,
		ST_IDLE      = 3'd2,
		ST_CONTINUES = 3'd3,
		ST_FINISHED  = 3'd4,
		ST_PREEMPTED = 3'd5,
		ST_DEMOTED   = 3'd6
	} status_t;

	// queue command: at most one pop and one push per cycle
	typedef struct packed {
		logic pop;
		lvl_t pop_lvl;
		logic push;
		lvl_t push_lvl;
	} q_cmd_t;

	// slot table command
	typedef struct packed {
		logic arrive;
		logic run;
		logic start;
		logic finish;
	} slot_cmd_t;

endpackage

`default_nettype wire

FILE: sv/mlfq_scheduler_unit.sv
// top level of the three-level feedback queue scheduler
//
// One transfer on the slave stream is one request: an arrival (tuser = 0) that
// puts a process slot with its burst into the top queue, or a tick (tuser = 1)
// that runs the current process for one unit. Every request gives exactly one
// result transfer on the master stream, with the status code in tuser. The
// block takes one request per clock while the result side accepts; a taken
// request waits in the input register, then the whole decision
// (pick, decrement, finish/preempt/demote test, at most one queue push) is one
// pass of logic into the result register. The rate is set by the per-item
// state loop: queue heads, the running slot and the slot tables are updated in
// that same cycle, and the slot and link memories are read in the cycle before,
// at the address the next state points to, with a bypass for same-edge writes.
// No clearing pass follows reset; the block is ready at the first clock.
// Quantum registers are written through the cfg port (index 0 top, 1 middle,
// 2 bottom, other indexes ignored); the user must write them only while no request
// is in flight, which the block does not enforce; a quantum of zero acts as one.
`default_nettype none

module mlfq_scheduler_unit #(
	parameter int PROC_SLOTS = 16,
	parameter int TIME_BITS  = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [mlfq_pkg::S_TDATA_W-1:0]   s_tdata,   // proc_id[3:0], burst_length[19:4], pad
	input  logic                             s_tuser,   // req_type
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [mlfq_pkg::M_TDATA_W-1:0]   m_tdata,   // run_id, run_level, time_stamp,
	                                                    // turnaround, waiting, response, pad
	output logic [mlfq_pkg::STATUS_W-1:0]    m_tuser,   // status
	// quantum register writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mlfq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mlfq_pkg::QUANT_W-1:0]     cfg_data
);
	import mlfq_pkg::*;

	localparam int SLOT_W = $clog2(PROC_SLOTS);
	typedef logic [SLOT_W-1:0] slot_t;

	// input register
	logic                s_valid_s1;
	logic                req_s1;
	logic [ID_W-1:0]     id_s1;
	logic [BURST_W-1:0]  burst_s1;

	// scheduler state
	quant_t              quant_q [LEVELS];
	logic [TIME_BITS-1:0] time_q;
	logic                run_valid_q;
	slot_t               run_slot_q;
	lvl_t                run_lvl_q;
	quant_t              slice_q;

	// result register
	logic                m_valid_q;
	status_t             m_status_q;
	logic [ID_W-1:0]     m_id_q;
	lvl_t                m_lvl_q;
	logic [STAMP_W-1:0]  m_stamp_q;
	logic [STAMP_W-1:0]  m_turn_q;
	logic [STAMP_W-1:0]  m_wait_q;
	logic [STAMP_W-1:0]  m_resp_q;

	// queue and slot table hookup
	q_cmd_t              qcmd;
	slot_cmd_t           scmd;
	logic [LEVELS-1:0]   nonempty;
	slot_t               pick_slot;
	slot_t               pick_slot_next;
	slot_t               push_slot;
	slot_t               rd_slot;
	logic [PROC_SLOTS-1:0] slot_active;
	logic                cur_started;
	logic [BURST_W-1:0]  cur_work;
	logic [BURST_W-1:0]  cur_burst;
	logic [TIME_BITS-1:0] cur_arrived;
	logic [TIME_BITS-1:0] cur_first;

	// decision logic
	logic                fire;
	logic                is_tick;
	logic                id_ok;
	slot_t               arr_slot;
	logic                arr_busy;
	logic                any_queued;
	logic                have_run;
	lvl_t                pick_lvl;
	slot_t               cur_slot;
	lvl_t                cur_lvl;
	quant_t              pick_quant;
	quant_t              slice_cur;
	quant_t              slice_new;
	logic [BURST_W-1:0]  work_new;
	logic                higher;
	logic [TIME_BITS-1:0] time_inc;
	logic [TIME_BITS-1:0] first_at;
	logic [TIME_BITS-1:0] turn_full;
	logic [TIME_BITS-1:0] resp_full;
	logic [STAMP_W-1:0]  turn16;

	status_t             st;
	logic [ID_W-1:0]     o_id;
	lvl_t                o_lvl;
	logic [STAMP_W-1:0]  o_turn;
	logic [STAMP_W-1:0]  o_wait;
	logic [STAMP_W-1:0]  o_resp;
	logic [TIME_BITS-1:0] time_n;
	logic                run_valid_n;
	slot_t               run_slot_n;
	lvl_t                run_lvl_n;
	quant_t              slice_n;

	// the request in the input register is worked off when the result register can take it
	assign fire      = s_valid_s1 && (!m_valid_q || m_tready);
	assign s_tready  = !s_valid_s1 || fire;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			s_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1   <= s_tuser;
			id_s1    <= s_tdata[ID_W-1:0];
			burst_s1 <= s_tdata[ID_W +: BURST_W];
		end
	end

	// arrival checks; a zero burst counts as one
	assign is_tick  = (req_s1 == REQ_TICK);
	assign id_ok    = int'(id_s1) < PROC_SLOTS;
	assign arr_slot = SLOT_W'(id_s1);
	assign arr_busy = !id_ok || slot_active[arr_slot];

	// pick: front of the highest non-empty level, used only when nothing runs
	assign any_queued = |nonempty;
	assign have_run   = run_valid_q || any_queued;
	assign pick_lvl   = nonempty[0] ? LVL_TOP : (nonempty[1] ? LVL_MID : LVL_BOT);
	assign pick_quant = quant_q[pick_lvl];
	assign cur_slot   = run_valid_q ? run_slot_q : pick_slot;
	assign cur_lvl    = run_valid_q ? run_lvl_q : pick_lvl;
	assign slice_cur  = run_valid_q ? slice_q :
	                    ((pick_quant == '0) ? quant_t'(1) : pick_quant);
	assign slice_new  = slice_cur - 1'b1;
	assign work_new   = cur_work - 1'b1;
	assign time_inc   = time_q + 1'b1;

	always_comb begin
		case (cur_lvl)
			LVL_MID: higher = nonempty[0];
			LVL_BOT: higher = nonempty[0] || nonempty[1];
			default: higher = 1'b0;
		endcase
	end

	// first run is now when the slot has never run before
	assign first_at  = cur_started ? cur_first : time_q;
	assign turn_full = time_inc - cur_arrived;
	assign resp_full = first_at - cur_arrived;
	assign turn16    = STAMP_W'(turn_full);

	assign push_slot = is_tick ? cur_slot : arr_slot;

	always_comb begin
		qcmd        = '0;
		scmd        = '0;
		st          = ST_IDLE;
		o_id        = '0;
		o_lvl       = LVL_TOP;
		o_turn      = '0;
		o_wait      = '0;
		o_resp      = '0;
		time_n      = time_q;
		run_valid_n = run_valid_q;
		run_slot_n  = run_slot_q;
		run_lvl_n   = run_lvl_q;
		slice_n     = slice_q;
		if (fire) begin
			if (!is_tick) begin
				o_id = id_s1;
				if (arr_busy) begin
					st = ST_REJECTED;
				end else begin
					st            = ST_ACCEPTED;
					scmd.arrive   = 1'b1;
					qcmd.push     = 1'b1;
					qcmd.push_lvl = LVL_TOP;
				end
			end else begin
				time_n = time_inc;
				if (have_run) begin
					qcmd.pop     = !run_valid_q;
					qcmd.pop_lvl = pick_lvl;
					scmd.run     = 1'b1;
					scmd.start   = !cur_started;
					o_id         = ID_W'(cur_slot);
					o_lvl        = cur_lvl;
					run_slot_n   = cur_slot;
					run_lvl_n    = cur_lvl;
					slice_n      = slice_new;
					run_valid_n  = 1'b0;
					if (work_new == '0) begin
						st          = ST_FINISHED;
						scmd.finish = 1'b1;
						o_turn      = turn16;
						o_wait      = turn16 - cur_burst;
						o_resp      = STAMP_W'(resp_full);
					end else if (higher) begin
						// back to the tail of its own level
						st            = ST_PREEMPTED;
						qcmd.push     = 1'b1;
						qcmd.push_lvl = cur_lvl;
					end else if (slice_new == '0) begin
						// slice used up: one level down, bottom stays
						st            = ST_DEMOTED;
						qcmd.push     = 1'b1;
						qcmd.push_lvl = (cur_lvl == LVL_BOT) ? LVL_BOT : lvl_t'(cur_lvl + 1'b1);
					end else begin
						st          = ST_CONTINUES;
						run_valid_n = 1'b1;
					end
				end
			end
		end
	end

	// slot tables are read at the slot the next state will work on
	assign rd_slot = run_valid_n ? run_slot_n : pick_slot_next;

	mlfq_queues #(
		.PROC_SLOTS(PROC_SLOTS)
	) u_queues (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (qcmd),
		.push_slot     (push_slot),
		.nonempty      (nonempty),
		.pick_slot     (pick_slot),
		.pick_slot_next(pick_slot_next)
	);

	mlfq_slots #(
		.PROC_SLOTS(PROC_SLOTS),
		.TIME_BITS (TIME_BITS)
	) u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (scmd),
		.arr_slot   (arr_slot),
		.arr_burst  ((burst_s1 == '0) ? BURST_W'(1) : burst_s1),
		.cur_slot   (cur_slot),
		.rd_slot    (rd_slot),
		.time_now   (time_q),
		.work_new   (work_new),
		.active     (slot_active),
		.cur_started(cur_started),
		.cur_work   (cur_work),
		.cur_burst  (cur_burst),
		.cur_arrived(cur_arrived),
		.cur_first  (cur_first)
	);

	// scheduler state and quantum registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				quant_q[l] <= QUANT_RESET[l];
			end
			time_q      <= '0;
			run_valid_q <= 1'b0;
			run_slot_q  <= '0;
			run_lvl_q   <= LVL_TOP;
			slice_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_QUANT_TOP: quant_q[0] <= cfg_data;
					CFG_QUANT_MID: quant_q[1] <= cfg_data;
					CFG_QUANT_BOT: quant_q[2] <= cfg_data;
					default: begin
					end
				endcase
			end
			time_q      <= time_n;
			run_valid_q <= run_valid_n;
			run_slot_q  <= run_slot_n;
			run_lvl_q   <= run_lvl_n;
			slice_q     <= slice_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q  <= 1'b0;
			m_status_q <= ST_IDLE;
		end else begin
			if (fire) begin
				m_valid_q  <= 1'b1;
				m_status_q <= st;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_id_q    <= o_id;
			m_lvl_q   <= o_lvl;
			m_stamp_q <= STAMP_W'(time_n);
			m_turn_q  <= o_turn;
			m_wait_q  <= o_wait;
			m_resp_q  <= o_resp;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, m_resp_q, m_wait_q, m_turn_q, m_stamp_q,
	                   m_lvl_q, m_id_q};

	// the running process always owns an active slot
	a_run_active: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> slot_active[run_slot_q])
		else $error("running slot is not active");

	// a process left running still has slice left
	a_run_slice: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid_q |-> (slice_q != '0))
		else $error("running process with empty slice");

	// every tick advances time by exactly one
	a_tick_time: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_tick) |=> (time_q == TIME_BITS'($past(time_q) + 1'b1)))
		else $error("tick did not advance time by one");

	// a tick with queued or running work is never reported idle
	a_tick_work: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && is_tick && have_run) |=> (m_tuser != ST_IDLE))
		else $error("tick with pending work reported idle");

endmodule

`default_nettype wire

FILE: sv/mlfq_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module mlfq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

FILE: sv/mlfq_queues.sv
// three level queues kept as linked lists over the process slots
`default_nettype none

module mlfq_queues #(
	parameter int PROC_SLOTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlfq_pkg::q_cmd_t              cmd,
	input  logic [$clog2(PROC_SLOTS)-1:0] push_slot,
	output logic [mlfq_pkg::LEVELS-1:0]   nonempty,
	output logic [$clog2(PROC_SLOTS)-1:0] pick_slot,
	output logic [$clog2(PROC_SLOTS)-1:0] pick_slot_next
);
	import mlfq_pkg::*;

	localparam int SLOT_W = $clog2(PROC_SLOTS);
	typedef logic [SLOT_W-1:0] slot_t;

	slot_t             head_q [LEVELS];
	slot_t             tail_q [LEVELS];
	logic [LEVELS-1:0] ne_q;
	slot_t             head_n [LEVELS];
	slot_t             tail_n [LEVELS];
	logic [LEVELS-1:0] ne_n;
	logic [LEVELS-1:0] ne_mid;
	logic              link_we;
	slot_t             link_wa;
	slot_t             link_rd;
	slot_t             succ;
	logic              fwd_q;
	slot_t             fwd_d_q;

	// successor of the current pick head, with bypass of last cycle's link write
	assign succ = fwd_q ? fwd_d_q : link_rd;

	always_comb begin
		link_we = 1'b0;
		link_wa = tail_q[0];
		for (int l = 0; l < LEVELS; l++) begin
			head_n[l] = head_q[l];
			tail_n[l] = tail_q[l];
			ne_mid[l] = ne_q[l];
			if (cmd.pop && cmd.pop_lvl == lvl_t'(l)) begin
				head_n[l] = succ;
				if (head_q[l] == tail_q[l]) begin
					ne_mid[l] = 1'b0;
				end
			end
			ne_n[l] = ne_mid[l];
			if (cmd.push && cmd.push_lvl == lvl_t'(l)) begin
				if (!ne_mid[l]) begin
					head_n[l] = push_slot;
				end
				link_we   = ne_mid[l];
				link_wa   = tail_q[l];
				tail_n[l] = push_slot;
				ne_n[l]   = 1'b1;
			end
		end
	end

	assign nonempty       = ne_q;
	assign pick_slot      = ne_q[0] ? head_q[0] : (ne_q[1] ? head_q[1] : head_q[2]);
	assign pick_slot_next = ne_n[0] ? head_n[0] : (ne_n[1] ? head_n[1] : head_n[2]);

	mlfq_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(PROC_SLOTS)
	) u_link (
		.clk    (clk),
		.wr_en  (link_we),
		.wr_addr(link_wa),
		.wr_data(push_slot),
		.rd_addr(pick_slot_next),
		.rd_data(link_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
			end
			ne_q    <= '0;
			fwd_q   <= 1'b0;
			fwd_d_q <= '0;
		end else begin
			for (int l = 0; l < LEVELS; l++) begin
				head_q[l] <= head_n[l];
				tail_q[l] <= tail_n[l];
			end
			ne_q    <= ne_n;
			fwd_q   <= link_we && (link_wa == pick_slot_next);
			fwd_d_q <= push_slot;
		end
	end

endmodule

`default_nettype wire

FILE: sv/mlfq_slots.sv
// per-slot bookkeeping: flags in flops, counters and time marks in ram
`default_nettype none

module mlfq_slots #(
	parameter int PROC_SLOTS = 16,
	parameter int TIME_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mlfq_pkg::slot_cmd_t            cmd,
	input  logic [$clog2(PROC_SLOTS)-1:0]  arr_slot,
	input  logic [mlfq_pkg::BURST_W-1:0]   arr_burst,
	input  logic [$clog2(PROC_SLOTS)-1:0]  cur_slot,
	input  logic [$clog2(PROC_SLOTS)-1:0]  rd_slot,
	input  logic [TIME_BITS-1:0]           time_now,
	input  logic [mlfq_pkg::BURST_W-1:0]   work_new,
	output logic [PROC_SLOTS-1:0]          active,
	output logic                           cur_started,
	output logic [mlfq_pkg::BURST_W-1:0]   cur_work,
	output logic [mlfq_pkg::BURST_W-1:0]   cur_burst,
	output logic [TIME_BITS-1:0]           cur_arrived,
	output logic [TIME_BITS-1:0]           cur_first
);
	import mlfq_pkg::*;

	localparam int SLOT_W = $clog2(PROC_SLOTS);
	localparam int AB_W   = TIME_BITS + BURST_W;

	logic [PROC_SLOTS-1:0] active_q;
	logic [PROC_SLOTS-1:0] started_q;

	logic                  work_we;
	logic [SLOT_W-1:0]     work_wa;
	logic [BURST_W-1:0]    work_wd;
	logic [BURST_W-1:0]    work_rd;
	logic [AB_W-1:0]       ab_wd;
	logic [AB_W-1:0]       ab_rd;
	logic [TIME_BITS-1:0]  first_rd;

	logic                  work_fwd_q;
	logic [BURST_W-1:0]    work_fwd_d_q;
	logic                  ab_fwd_q;
	logic [AB_W-1:0]       ab_fwd_d_q;
	logic                  first_fwd_q;
	logic [TIME_BITS-1:0]  first_fwd_d_q;
	logic [AB_W-1:0]       ab_cur;

	assign work_we = cmd.arrive || cmd.run;
	assign work_wa = cmd.arrive ? arr_slot : cur_slot;
	assign work_wd = cmd.arrive ? arr_burst : work_new;
	assign ab_wd   = {time_now, arr_burst};

	mlfq_ram #(.WIDTH(BURST_W), .DEPTH(PROC_SLOTS)) u_work (
		.clk    (clk),
		.wr_en  (work_we),
		.wr_addr(work_wa),
		.wr_data(work_wd),
		.rd_addr(rd_slot),
		.rd_data(work_rd)
	);

	mlfq_ram #(.WIDTH(AB_W), .DEPTH(PROC_SLOTS)) u_arrival (
		.clk    (clk),
		.wr_en  (cmd.arrive),
		.wr_addr(arr_slot),
		.wr_data(ab_wd),
		.rd_addr(rd_slot),
		.rd_data(ab_rd)
	);

	mlfq_ram #(.WIDTH(TIME_BITS), .DEPTH(PROC_SLOTS)) u_first (
		.clk    (clk),
		.wr_en  (cmd.start),
		.wr_addr(cur_slot),
		.wr_data(time_now),
		.rd_addr(rd_slot),
		.rd_data(first_rd)
	);

	// reads were issued in the cycle before; bypass writes that landed at the same edge
	assign cur_work    = work_fwd_q ? work_fwd_d_q : work_rd;
	assign ab_cur      = ab_fwd_q ? ab_fwd_d_q : ab_rd;
	assign cur_first   = first_fwd_q ? first_fwd_d_q : first_rd;
	assign cur_burst   = ab_cur[BURST_W-1:0];
	assign cur_arrived = ab_cur[AB_W-1:BURST_W];
	assign cur_started = started_q[cur_slot];
	assign active      = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			started_q   <= '0;
			work_fwd_q  <= 1'b0;
			ab_fwd_q    <= 1'b0;
			first_fwd_q <= 1'b0;
		end else begin
			if (cmd.arrive) begin
				active_q[arr_slot]  <= 1'b1;
				started_q[arr_slot] <= 1'b0;
			end
			if (cmd.start) begin
				started_q[cur_slot] <= 1'b1;
			end
			if (cmd.finish) begin
				active_q[cur_slot] <= 1'b0;
			end
			work_fwd_q  <= work_we && (work_wa == rd_slot);
			ab_fwd_q    <= cmd.arrive && (arr_slot == rd_slot);
			first_fwd_q <= cmd.start && (cur_slot == rd_slot);
		end
	end

	always_ff @(posedge clk) begin
		work_fwd_d_q  <= work_wd;
		ab_fwd_d_q    <= ab_wd;
		first_fwd_d_q <= time_now;
	end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// self-checking testbench for the three-level feedback queue scheduler
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mlfq_pkg::*;

	// index past the last quantum register, writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam int SLOTS        = 16;
	localparam int PHASE_ITEMS  = 280;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 4;

	// request word on s_tdata, lowest field last
	typedef struct packed {
		logic [S_TDATA_W-ID_W-BURST_W-1:0] pad;
		logic [BURST_W-1:0]                burst;
		logic [ID_W-1:0]                   id;
	} request_word_t;

	// result word on m_tdata, lowest field last
	typedef struct packed {
		logic [M_PAD_W-1:0]  pad;
		logic [STAMP_W-1:0]  response;
		logic [STAMP_W-1:0]  waiting;
		logic [STAMP_W-1:0]  turnaround;
		logic [STAMP_W-1:0]  stamp;
		lvl_t                run_level;
		logic [ID_W-1:0]     run_id;
	} result_word_t;

	// one predicted scheduler outcome
	typedef struct packed {
		status_t             status;
		logic [ID_W-1:0]     run_id;
		lvl_t                run_level;
		logic [STAMP_W-1:0]  stamp;
		logic [STAMP_W-1:0]  turnaround;
		logic [STAMP_W-1:0]  waiting;
		logic [STAMP_W-1:0]  response;
	} sched_result_t;

	// how eagerly the result side takes transfers
	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_COIN,
		PACE_SPARSE,
		PACE_DENSE
	} pace_t;

	// scheduler predictor plus the store of outcomes still to arrive
	class sched_scoreboard;
		quant_t              quantum [LEVELS];
		logic [STAMP_W-1:0]  clock_now;
		logic [ID_W-1:0]     ring [LEVELS][SLOTS];
		int                  ring_head [LEVELS];
		int                  ring_count [LEVELS];
		bit                  active [SLOTS];
		bit                  started [SLOTS];
		logic [BURST_W-1:0]  work_left [SLOTS];
		logic [BURST_W-1:0]  burst_len [SLOTS];
		logic [STAMP_W-1:0]  arrived [SLOTS];
		logic [STAMP_W-1:0]  first_run [SLOTS];
		bit                  running;
		logic [ID_W-1:0]     run_slot;
		lvl_t                run_lvl;
		quant_t              slice;
		sched_result_t       outcomes [$];
		int                  errors;

		function new();
			quantum   = QUANT_RESET;
			clock_now = '0;
			running   = 1'b0;
			run_slot  = '0;
			run_lvl   = LVL_TOP;
			slice     = '0;
			errors    = 0;
			foreach (ring_head[i]) begin
				ring_head[i]  = 0;
				ring_count[i] = 0;
			end
			foreach (active[i]) begin
				active[i]  = 1'b0;
				started[i] = 1'b0;
			end
		endfunction

		// append at the tail of a level, the tail sits count places past the head
		function void enqueue(lvl_t lv, logic [ID_W-1:0] slot);
			ring[lv][(ring_head[lv] + ring_count[lv]) % SLOTS] = slot;
			ring_count[lv]++;
		endfunction

		function void note_quantum(logic [CFG_IDX_W-1:0] idx, quant_t val);
			case (idx)
				CFG_QUANT_TOP: quantum[LVL_TOP] = val;
				CFG_QUANT_MID: quantum[LVL_MID] = val;
				CFG_QUANT_BOT: quantum[LVL_BOT] = val;
				default: ;
			endcase
		endfunction

		function void note_request(logic kind, logic [ID_W-1:0] id, logic [BURST_W-1:0] burst);
			sched_result_t r;
			bit            higher;
			lvl_t          next_lvl;
			r = '0;
			if (kind == REQ_ARRIVE) begin
				r.run_id = id;
				if (active[id]) begin
					r.status = ST_REJECTED;
				end else begin
					active[id]    = 1'b1;
					started[id]   = 1'b0;
					work_left[id] = (burst == '0) ? BURST_W'(1) : burst;
					burst_len[id] = work_left[id];
					arrived[id]   = clock_now;
					enqueue(LVL_TOP, id);
					r.status = ST_ACCEPTED;
				end
			end else begin
				// an idle core first takes the head of the highest busy level
				if (!running) begin
					for (int lv = 0; lv < LEVELS; lv++) begin
						if (!running && ring_count[lv] != 0) begin
							run_slot      = ring[lv][ring_head[lv]];
							ring_head[lv] = (ring_head[lv] + 1) % SLOTS;
							ring_count[lv]--;
							running = 1'b1;
							run_lvl = lvl_t'(lv);
							slice   = (quantum[lv] == '0) ? quant_t'(1) : quantum[lv];
							if (!started[run_slot]) begin
								started[run_slot]   = 1'b1;
								first_run[run_slot] = clock_now;
							end
						end
					end
				end
				clock_now++;
				if (!running) begin
					r.status = ST_IDLE;
				end else begin
					work_left[run_slot]--;
					slice--;
					higher = 1'b0;
					for (int k = 0; k < run_lvl; k++)
						if (ring_count[k] != 0)
							higher = 1'b1;
					r.run_id    = run_slot;
					r.run_level = run_lvl;
					if (work_left[run_slot] == '0) begin
						r.turnaround = clock_now - arrived[run_slot];
						r.waiting    = r.turnaround - burst_len[run_slot];
						r.response   = first_run[run_slot] - arrived[run_slot];
						active[run_slot] = 1'b0;
						running  = 1'b0;
						r.status = ST_FINISHED;
					end else if (higher) begin
						running = 1'b0;
						enqueue(run_lvl, run_slot);
						r.status = ST_PREEMPTED;
					end else if (slice == '0) begin
						next_lvl = (run_lvl == LVL_BOT) ? LVL_BOT : lvl_t'(run_lvl + 1);
						running  = 1'b0;
						enqueue(next_lvl, run_slot);
						r.status = ST_DEMOTED;
					end else begin
						r.status = ST_CONTINUES;
					end
				end
			end
			r.stamp = clock_now;
			outcomes = {outcomes, r};
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [STATUS_W-1:0] status, logic [M_TDATA_W-1:0] data);
			result_word_t  w;
			sched_result_t e;
			w = data;
			if (outcomes.size() == 0) begin
				$display("%0t: result with nothing pending, expected none, actual status %0d data %h",
					$time, status, data);
				errors++;
				return;
			end
			e = outcomes.pop_front();
			compare_field("status", 16'(e.status), 16'(status));
			compare_field("run_id", 16'(e.run_id), 16'(w.run_id));
			compare_field("run_level", 16'(e.run_level), 16'(w.run_level));
			compare_field("time_stamp", e.stamp, w.stamp);
			compare_field("turnaround", e.turnaround, w.turnaround);
			compare_field("waiting", e.waiting, w.waiting);
			compare_field("response", e.response, w.response);
		endfunction

		function int pending();
			return outcomes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // proc_id, burst_length, pad
	logic                  s_tuser;   // req_type
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;   // run_id, run_level, time_stamp, turnaround, waiting, response, pad
	logic [STATUS_W-1:0]   m_tuser;   // status
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [QUANT_W-1:0]    cfg_data;

	sched_scoreboard sb = new();

	// long result-side hold-offs asked by the stimulus and served by the receiver
	int hold_asks  = 0;
	int holds_done = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	mlfq_scheduler_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// offer one request and hold it until the transfer, valid stays high afterwards
	task automatic send_item(input logic kind, input logic [ID_W-1:0] id,
			input logic [BURST_W-1:0] burst);
		request_word_t w;
		w       = '0;
		w.id    = id;
		w.burst = burst;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		sb.note_request(kind, id, burst);
	endtask

	task automatic idle_cycles(input int n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop offering and let every pending result come back, then settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write all three quanta back to back, optionally followed by a write to the
	// unused index carrying random data
	task automatic program_quanta(input quant_t top, input quant_t mid, input quant_t bot,
			input bit poke_unused);
		logic [CFG_IDX_W-1:0] idx [4];
		quant_t               val [4];
		int                   n;
		idx = '{CFG_QUANT_TOP, CFG_QUANT_MID, CFG_QUANT_BOT, CFG_UNUSED};
		val = '{top, mid, bot, quant_t'($urandom)};
		n   = poke_unused ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
			sb.note_quantum(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// random request: arrivals get likelier the more slots are free, so the
	// queues stay loaded without every arrival bouncing off a busy slot
	task automatic random_request();
		logic [ID_W-1:0]     free_ids [$];
		logic [ID_W-1:0]     id;
		logic [BURST_W-1:0]  burst;
		int                  pick;
		foreach (sb.active[i])
			if (!sb.active[i])
				free_ids = {free_ids, ID_W'(i)};
		if ($urandom_range(0, 99) < 4 + 2 * free_ids.size()) begin
			if (free_ids.size() != 0 && $urandom_range(0, 7) != 0)
				id = free_ids[$urandom_range(0, free_ids.size() - 1)];
			else
				id = ID_W'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 65)
				burst = BURST_W'($urandom_range(1, 6));
			else if (pick < 94)
				burst = BURST_W'($urandom_range(7, 40));
			else if (pick < 99)
				burst = BURST_W'($urandom_range(41, 300));
			else
				burst = BURST_W'($urandom);
			send_item(REQ_ARRIVE, id, burst);
		end else begin
			// a tick ignores the slot and burst fields, so fill them with noise
			send_item(REQ_TICK, ID_W'($urandom), BURST_W'($urandom));
		end
	endtask

	// result side: checks every transfer and stalls on its own pace pattern
	initial begin
		pace_t pace;
		int    pace_left;
		int    hold_left;
		pace      = PACE_FULL;
		pace_left = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
			if (hold_left > 0) begin
				// long hold-off so the pipeline fills and the request side stalls
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_asks != holds_done) begin
				holds_done++;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				if (pace_left == 0) begin
					pace      = pace_t'($urandom_range(0, 3));
					pace_left = $urandom_range(20, 150);
				end
				pace_left--;
				case (pace)
					PACE_FULL:   m_tready <= 1'b1;
					PACE_COIN:   m_tready <= 1'($urandom_range(0, 1));
					PACE_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
					default:     m_tready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// request side and phase sequencing
	initial begin
		quant_t phase_q [5][3];
		int     sent;
		int     run_len;
		int     gap;
		phase_q = '{'{10'd4, 10'd8, 10'd16}, '{10'd1, 10'd1, 10'd1},
			'{10'd1023, 10'd1023, 10'd1023}, '{10'd0, 10'd1023, 10'd1},
			'{quant_t'($urandom_range(1, 20)), quant_t'($urandom_range(1, 20)),
				quant_t'($urandom_range(1, 20))}};
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= REQ_TICK;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_QUANT_TOP;
		cfg_data  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: short top slice, bottom quantum of zero acting as one
		program_quanta(10'd2, 10'd3, 10'd0, 1'b1);
		send_item(REQ_TICK, 4'hf, 16'hffff);       // nothing queued: idle tick
		send_item(REQ_ARRIVE, 4'h0, 16'h0000);     // zero burst counts as one unit
		send_item(REQ_ARRIVE, 4'h0, 16'h0005);     // slot already active: rejected
		send_item(REQ_ARRIVE, 4'hf, 16'hffff);     // longest burst, highest slot
		send_item(REQ_TICK, 4'h0, 16'h0000);       // slot 0 done in one unit
		send_item(REQ_TICK, 4'h0, 16'h0000);
		send_item(REQ_TICK, 4'h0, 16'h0000);       // top slice used up: demoted
		send_item(REQ_ARRIVE, 4'ha, 16'h0003);
		send_item(REQ_TICK, 4'h0, 16'h0000);
		send_item(REQ_TICK, 4'h0, 16'h0000);       // demoted with a unit left
		send_item(REQ_TICK, 4'h0, 16'h0000);       // middle level takes over
		send_item(REQ_ARRIVE, 4'h3, 16'h0002);
		send_item(REQ_TICK, 4'h0, 16'h0000);       // top queue busy: preempted
		send_item(REQ_TICK, 4'h0, 16'h0000);
		send_item(REQ_TICK, 4'h0, 16'h0000);
		repeat (8) send_item(REQ_TICK, 4'h0, 16'h0000);  // bottom level keeps its slot there

		// random phases, each under its own quanta; config only once drained
		for (int p = 0; p < 5; p++) begin
			wait_drained();
			program_quanta(phase_q[p][0], phase_q[p][1], phase_q[p][2], p == 4);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				run_len = $urandom_range(1, 24);
				for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++) begin
					if (p == 1 && sent == 60)
						hold_asks++;
					if (p == 3 && sent == 140)
						wait_drained();
					random_request();
					sent++;
				end
				// one phase runs back to back, the rest sometimes idle between bursts
				if (p == 2 || $urandom_range(0, 3) == 0)
					gap = 0;
				else
					gap = $urandom_range(1, 6);
				idle_cycles(gap);
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

endmodule
